/* rtl/assert_macros.svh */
// Assertion helpers used by the checker in rtl/trs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TRS_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TRS_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/trs_pkg.sv */
// ----------------------------------------------------------------------------
// trs_pkg
// Types and codes shared by the thread scheduler cells and control.
// ----------------------------------------------------------------------------
package trs_pkg;

	typedef enum logic [2:0] {
		ST_UNUSED   = 3'd0,
		ST_RUNNABLE = 3'd1,
		ST_RUNNING  = 3'd2,
		ST_SLEEPING = 3'd3,
		ST_ZOMBIE   = 3'd4
	} slot_state_t;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_YIELD  = 2'd1,
		CMD_EXIT   = 2'd2,
		CMD_JOIN   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_SLOT   = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_BLOCKED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CREATE,
		OP_CUR_RUNNABLE,
		OP_EXIT,
		OP_JOIN_FREE,
		OP_SLEEP,
		OP_PICK
	} cell_op_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_CREATE,
		FS_JOIN,
		FS_SCHED,
		FS_DONE
	} fsm_t;

	typedef struct packed {
		cell_op_t op;
		logic     tok_load;
	} cell_ctl_t;

endpackage

/* rtl/trs_cell.sv */
// ----------------------------------------------------------------------------
// trs_cell
// One thread slot: state, id, join target and value, plus the scan token
// that passes to the next cell every cycle unless it is reloaded.
// ----------------------------------------------------------------------------
module trs_cell #(
	parameter int ID_BITS    = 16,
	parameter int VALUE_BITS = 32,
	parameter bit FIRST      = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  trs_pkg::cell_ctl_t     ctl,
	input  logic                   load_here,
	input  logic                   tok_in,
	input  logic                   is_cur,
	input  logic [ID_BITS-1:0]     new_id,
	input  logic [ID_BITS-1:0]     me_id,
	input  logic [ID_BITS-1:0]     tgt_id,
	input  logic [VALUE_BITS-1:0]  exit_value,
	output logic                   tok,
	output trs_pkg::slot_state_t   state,
	output logic [ID_BITS-1:0]     id,
	output logic [VALUE_BITS-1:0]  value
);
	import trs_pkg::*;

	slot_state_t            state_q;
	logic [ID_BITS-1:0]     id_q;
	logic [ID_BITS-1:0]     jid_q;
	logic                   jv_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic                   tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FIRST ? ST_RUNNING : ST_UNUSED;
			id_q    <= '0;
			jid_q   <= '0;
			jv_q    <= 1'b0;
			value_q <= '0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= ctl.tok_load ? load_here : tok_in;
			unique case (ctl.op)
				OP_CREATE: begin
					if (tok_q) begin
						state_q <= ST_RUNNABLE;
						id_q    <= new_id;
						value_q <= '0;
						jv_q    <= 1'b0;
						jid_q   <= '0;
					end
				end
				OP_CUR_RUNNABLE: begin
					if (is_cur) state_q <= ST_RUNNABLE;
				end
				OP_EXIT: begin
					if (is_cur) begin
						value_q <= exit_value;
						state_q <= ST_ZOMBIE;
					end else if (state_q == ST_SLEEPING && jv_q && jid_q == me_id) begin
						state_q <= ST_RUNNABLE;
						jv_q    <= 1'b0;
					end
				end
				OP_JOIN_FREE: begin
					if (tok_q) begin
						state_q <= ST_UNUSED;
						id_q    <= '0;
					end
				end
				OP_SLEEP: begin
					if (is_cur) begin
						jv_q    <= 1'b1;
						jid_q   <= tgt_id;
						state_q <= ST_SLEEPING;
					end
				end
				OP_PICK: begin
					if (tok_q) state_q <= ST_RUNNING;
					else if (is_cur && state_q == ST_RUNNING) state_q <= ST_RUNNABLE;
				end
				default: ;
			endcase
		end
	end

	assign tok   = tok_q;
	assign state = state_q;
	assign id    = id_q;
	assign value = value_q;

endmodule

/* rtl/round_robin_thread_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread slot table with create, yield, exit and join events and round-robin
// selection of the next runnable slot.
// ----------------------------------------------------------------------------
// Usage: drive cmd, target_id and exit_value with start while busy is low;
// the event is taken at that edge and busy rises. One result per event
// appears on status, new_id, joined_value, running_slot, running_id and
// switched, marked by done for exactly one cycle; busy falls after it.
// The slots form a ring of cells; a scan token moves one cell per cycle
// unless it is reloaded. Create and join search the ring from slot 0;
// yield and exit search at most one ring lap, from the slot after the
// running one, for a runnable slot; a join that blocks searches, then laps.
// After done the scheduler returns to idle, where the next start is taken.
// Reset: slot 0 running with id 0, all other slots unused, next id one.
// The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
	parameter int SLOT_COUNT = 16,
	parameter int ID_BITS    = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             cmd,
	input  logic [ID_BITS-1:0]     target_id,
	input  logic [VALUE_BITS-1:0]  exit_value,
	output logic                   done,
	output logic [1:0]             status,
	output logic [ID_BITS-1:0]     new_id,
	output logic [VALUE_BITS-1:0]  joined_value,
	output logic [3:0]             running_slot,
	output logic [ID_BITS-1:0]     running_id,
	output logic                   switched
);
	import trs_pkg::*;

	localparam int SW = $clog2(SLOT_COUNT);

	fsm_t                   fsm_q, fsm_d;
	cell_ctl_t              ctl;
	logic [SW-1:0]          load_ptr;
	logic [SW-1:0]          ptr_q, ptr_inc, cur_inc;
	logic [SW-1:0]          cnt_q;
	logic [SW-1:0]          cur_q;
	logic [ID_BITS-1:0]     next_id_q;
	logic [ID_BITS-1:0]     tgt_q;
	status_t                status_q;
	logic [ID_BITS-1:0]     new_id_q;
	logic [VALUE_BITS-1:0]  joined_q;
	logic                   sw_q;

	logic                   tok   [SLOT_COUNT];
	slot_state_t            c_st  [SLOT_COUNT];
	logic [ID_BITS-1:0]     c_id  [SLOT_COUNT];
	logic [VALUE_BITS-1:0]  c_val [SLOT_COUNT];

	slot_state_t            sel_state;
	logic [ID_BITS-1:0]     sel_id;
	logic [VALUE_BITS-1:0]  sel_value;
	logic [ID_BITS-1:0]     cur_id;
	logic                   last, create_hit, join_hit, sched_hit;

	genvar g;
	generate
		for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
			trs_cell #(
				.ID_BITS(ID_BITS),
				.VALUE_BITS(VALUE_BITS),
				.FIRST(g == 0)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.load_here(load_ptr == SW'(g)),
				.tok_in(tok[(g + SLOT_COUNT - 1) % SLOT_COUNT]),
				.is_cur(cur_q == SW'(g)),
				.new_id(next_id_q),
				.me_id(cur_id),
				.tgt_id(tgt_q),
				.exit_value(exit_value),
				.tok(tok[g]),
				.state(c_st[g]),
				.id(c_id[g]),
				.value(c_val[g])
			);
		end
	endgenerate

	always_comb begin
		sel_state = ST_UNUSED;
		sel_id    = '0;
		sel_value = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (tok[i]) begin
				sel_state = slot_state_t'(sel_state | c_st[i]);
				sel_id    = sel_id | c_id[i];
				sel_value = sel_value | c_val[i];
			end
		end
	end

	assign cur_id     = c_id[cur_q];
	assign ptr_inc    = (ptr_q == SW'(SLOT_COUNT - 1)) ? '0 : SW'(ptr_q + 1'b1);
	assign cur_inc    = (cur_q == SW'(SLOT_COUNT - 1)) ? '0 : SW'(cur_q + 1'b1);
	assign last       = cnt_q == SW'(SLOT_COUNT - 1);
	assign create_hit = sel_state == ST_UNUSED;
	assign join_hit   = sel_state != ST_UNUSED && sel_id == tgt_q;
	assign sched_hit  = sel_state == ST_RUNNABLE;

	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			FS_IDLE: begin
				if (start) begin
					unique case (cmd_t'(cmd))
						CMD_CREATE: fsm_d = FS_CREATE;
						CMD_JOIN:   fsm_d = FS_JOIN;
						default:    fsm_d = FS_SCHED;
					endcase
				end
			end
			FS_CREATE: if (create_hit || last) fsm_d = FS_DONE;
			FS_JOIN: begin
				if (join_hit) fsm_d = (sel_state == ST_ZOMBIE) ? FS_DONE : FS_SCHED;
				else if (last) fsm_d = FS_DONE;
			end
			FS_SCHED: if (sched_hit || last) fsm_d = FS_DONE;
			FS_DONE:  fsm_d = FS_IDLE;
			default:  fsm_d = FS_IDLE;
		endcase
	end

	always_comb begin
		ctl.op       = OP_NONE;
		ctl.tok_load = 1'b0;
		load_ptr     = '0;
		unique case (fsm_q)
			FS_IDLE: begin
				if (start) begin
					ctl.tok_load = 1'b1;
					unique case (cmd_t'(cmd))
						CMD_YIELD: begin
							ctl.op   = OP_CUR_RUNNABLE;
							load_ptr = cur_inc;
						end
						CMD_EXIT: begin
							ctl.op   = OP_EXIT;
							load_ptr = cur_inc;
						end
						default: load_ptr = '0;
					endcase
				end
			end
			FS_CREATE: if (create_hit) ctl.op = OP_CREATE;
			FS_JOIN: begin
				if (join_hit) begin
					if (sel_state == ST_ZOMBIE) begin
						ctl.op = OP_JOIN_FREE;
					end else begin
						ctl.op       = OP_SLEEP;
						ctl.tok_load = 1'b1;
						load_ptr     = cur_inc;
					end
				end
			end
			FS_SCHED: if (sched_hit) ctl.op = OP_PICK;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= FS_IDLE;
			cur_q     <= '0;
			next_id_q <= ID_BITS'(1);
			ptr_q     <= '0;
			cnt_q     <= '0;
			status_q  <= STS_OK;
			sw_q      <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (ctl.tok_load) begin
				ptr_q <= load_ptr;
				cnt_q <= '0;
			end else begin
				ptr_q <= ptr_inc;
				cnt_q <= SW'(cnt_q + 1'b1);
			end
			unique case (fsm_q)
				FS_IDLE: begin
					if (start) begin
						status_q <= STS_OK;
						sw_q     <= 1'b0;
					end
				end
				FS_CREATE: begin
					if (create_hit) next_id_q <= ID_BITS'(next_id_q + 1'b1);
					else if (last) status_q <= STS_NO_SLOT;
				end
				FS_JOIN: begin
					if (join_hit) begin
						if (sel_state != ST_ZOMBIE) status_q <= STS_BLOCKED;
					end else if (last) begin
						status_q <= STS_NOT_FOUND;
					end
				end
				FS_SCHED: begin
					if (sched_hit) begin
						sw_q  <= ptr_q != cur_q;
						cur_q <= ptr_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fsm_q == FS_IDLE && start) begin
			tgt_q    <= target_id;
			new_id_q <= '0;
			joined_q <= '0;
		end else if (fsm_q == FS_CREATE && create_hit) begin
			new_id_q <= next_id_q;
		end else if (fsm_q == FS_JOIN && join_hit && sel_state == ST_ZOMBIE) begin
			joined_q <= sel_value;
		end
	end

	assign busy         = fsm_q != FS_IDLE;
	assign done         = fsm_q == FS_DONE;
	assign status       = status_q;
	assign new_id       = new_id_q;
	assign joined_value = joined_q;
	assign running_slot = 4'(cur_q);
	assign running_id   = cur_id;
	assign switched     = sw_q;

endmodule

/* rtl/trs_checker.sv */
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks of the scheduler command transaction sequence.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trs_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic done
);

	`TRS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted transaction did not raise busy")
	`TRS_ASSERT(a_done_busy, clk, arst_n, !done || busy, "result strobe while idle")
	`TRS_ASSERT_NEXT(a_done_release, clk, arst_n, done, !busy && !done, "busy held after result")
	`TRS_ASSERT_NEXT(a_no_spurious, clk, arst_n, !busy, !done, "result without accepted transaction")

endmodule

bind round_robin_thread_scheduler trs_checker u_trs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done)
);

/* tb/trs_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trs_tb_checker
// Watches the command and result channels of the thread scheduler, keeps its
// own copy of the slot table, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module trs_tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] target_id,
	input  logic [31:0] exit_value,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [15:0] new_id,
	input  logic [31:0] joined_value,
	input  logic [3:0]  running_slot,
	input  logic [15:0] running_id,
	input  logic        switched,
	output int          fail_count,
	output int          pending
);
	import trs_pkg::*;

	typedef struct packed {
		logic [1:0]  sts;
		logic [15:0] nid;
		logic [31:0] jval;
		logic [3:0]  rslot;
		logic [15:0] rid;
		logic        sw;
	} sched_result_t;

	slot_state_t   tbl_state [16];
	logic [15:0]   tbl_id    [16];
	logic          tbl_jv    [16];
	logic [15:0]   tbl_jid   [16];
	logic [31:0]   tbl_val   [16];
	logic [3:0]    cur;
	logic [15:0]   id_ctr;
	sched_result_t expected_q [$];

	function automatic logic pick_next();
		logic [3:0] s;
		for (int i = 1; i <= 16; i++) begin
			s = cur + i[3:0];
			if (tbl_state[s] == ST_RUNNABLE) begin
				if (tbl_state[cur] == ST_RUNNING)
					tbl_state[cur] = ST_RUNNABLE;
				tbl_state[s] = ST_RUNNING;
				pick_next = (s != cur);
				cur = s;
				return pick_next;
			end
		end
		return 1'b0;
	endfunction

	function automatic sched_result_t predict_event(cmd_t c, logic [15:0] tgt, logic [31:0] v);
		sched_result_t r;
		int f;
		logic [15:0] me;
		r = '0;
		f = 16;
		case (c)
			CMD_CREATE: begin
				for (int i = 0; i < 16; i++)
					if (f == 16 && tbl_state[i] == ST_UNUSED) f = i;
				if (f == 16) r.sts = STS_NO_SLOT;
				else begin
					tbl_id[f] = id_ctr;
					r.nid = id_ctr;
					id_ctr = id_ctr + 16'd1;
					tbl_state[f] = ST_RUNNABLE;
					tbl_val[f] = '0;
					tbl_jv[f] = 1'b0;
					tbl_jid[f] = '0;
				end
			end
			CMD_YIELD: begin
				tbl_state[cur] = ST_RUNNABLE;
				r.sw = pick_next();
			end
			CMD_EXIT: begin
				me = tbl_id[cur];
				tbl_val[cur] = v;
				tbl_state[cur] = ST_ZOMBIE;
				for (int i = 0; i < 16; i++)
					if (tbl_state[i] == ST_SLEEPING && tbl_jv[i] && tbl_jid[i] == me) begin
						tbl_state[i] = ST_RUNNABLE;
						tbl_jv[i] = 1'b0;
					end
				r.sw = pick_next();
			end
			default: begin
				for (int i = 0; i < 16; i++)
					if (f == 16 && tbl_id[i] == tgt && tbl_state[i] != ST_UNUSED) f = i;
				if (f == 16) r.sts = STS_NOT_FOUND;
				else if (tbl_state[f] == ST_ZOMBIE) begin
					r.jval = tbl_val[f];
					tbl_state[f] = ST_UNUSED;
					tbl_id[f] = '0;
				end else begin
					tbl_jv[cur] = 1'b1;
					tbl_jid[cur] = tgt;
					tbl_state[cur] = ST_SLEEPING;
					r.sw = pick_next();
					r.sts = STS_BLOCKED;
				end
			end
		endcase
		r.rslot = cur;
		r.rid = tbl_id[cur];
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		sched_result_t got;
		sched_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				tbl_state[i] = ST_UNUSED;
				tbl_id[i] = '0;
				tbl_jv[i] = 1'b0;
				tbl_jid[i] = '0;
				tbl_val[i] = '0;
			end
			tbl_state[0] = ST_RUNNING;
			cur = '0;
			id_ctr = 16'd1;
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (done) begin
				got = '{status, new_id, joined_value, running_slot, running_id, switched};
				if (expected_q.size() == 0) begin
					$display("%0t: result with no transaction pending, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected sts=%0d nid=%h jval=%h slot=%0d id=%h sw=%b",
							$time, exp_r.sts, exp_r.nid, exp_r.jval, exp_r.rslot, exp_r.rid, exp_r.sw);
						$display("%0t:          actual   sts=%0d nid=%h jval=%h slot=%0d id=%h sw=%b",
							$time, got.sts, got.nid, got.jval, got.rslot, got.rid, got.sw);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_event(cmd_t'(cmd), target_id, exit_value));
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the thread scheduler: directed events for table full, join of
// self and zombie collection, then random event mixes under varying sender
// idling. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import trs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [15:0] target_id;
	logic [31:0] exit_value;
	logic        done;
	logic [1:0]  status;
	logic [15:0] new_id;
	logic [31:0] joined_value;
	logic [3:0]  running_slot;
	logic [15:0] running_id;
	logic        switched;
	int          fail_count;
	int          pending;
	int          cycle_count;
	int          idle_pct;
	logic [15:0] recent_ids [$];

	round_robin_thread_scheduler u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.target_id(target_id), .exit_value(exit_value), .done(done), .status(status),
		.new_id(new_id), .joined_value(joined_value), .running_slot(running_slot),
		.running_id(running_id), .switched(switched)
	);

	trs_tb_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("[round_robin_thread_scheduler] ERROR");
				$finish;
			end
		end
	end

	always @(posedge clk)
		if (done && new_id != 16'd0) begin
			recent_ids.push_back(new_id);
			if (recent_ids.size() > 24) void'(recent_ids.pop_front());
		end

	// busy only moves at the rising edge, so its value at the falling edge
	// tells whether the next rising edge takes the transaction
	task automatic send_event(cmd_t c, logic [15:0] tgt, logic [31:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		target_id <= tgt;
		exit_value <= v;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_target();
		int r;
		r = $urandom_range(9);
		if (r == 0 || recent_ids.size() == 0) return 16'($urandom);
		if (r == 1) return running_id;
		return recent_ids[$urandom_range(recent_ids.size() - 1)];
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_CREATE;
		target_id = '0;
		exit_value = '0;
		idle_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_event(CMD_YIELD, 16'h0000, 32'h0);
		send_event(CMD_JOIN, 16'hffff, 32'h0);
		for (int i = 0; i < 16; i++) send_event(CMD_CREATE, 16'h0, 32'h0);
		send_event(CMD_YIELD, 16'h0, 32'h0);
		send_event(CMD_EXIT, 16'h0, 32'hffffffff);
		send_event(CMD_JOIN, 16'd1, 32'h0);
		send_event(CMD_JOIN, 16'd2, 32'h0);
		send_event(CMD_EXIT, 16'h0, 32'h0);
		send_event(CMD_JOIN, running_id, 32'h0);
		send_event(CMD_JOIN, 16'd0, 32'h0);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 47 : (ph == 3) ? 32 : 0;
			for (int k = 0; k < 410; k++) begin
				n = $urandom_range(99);
				if (n < 30) send_event(CMD_CREATE, 16'($urandom), $urandom);
				else if (n < 50) send_event(CMD_YIELD, 16'($urandom), $urandom);
				else if (n < 72) send_event(CMD_EXIT, 16'($urandom), $urandom);
				else send_event(CMD_JOIN, pick_target(), $urandom);
			end
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("[round_robin_thread_scheduler] OK");
		else
			$display("[round_robin_thread_scheduler] ERROR");
		$finish;
	end

endmodule
